FILE: hdl/hmtmb_pkg.sv
package hmtmb_pkg;

   // grid dimension registers and derived counts
   localparam int DIM_W   = 9;
   localparam int NV_W    = 2 * DIM_W;
   localparam int NT_W    = NV_W + 1;
   localparam int IDX_W   = 17;
   localparam int HGT_W   = 8;

   // normal arithmetic
   localparam int VEC_W   = 17;
   localparam int NRM_W   = 16;
   localparam int MAG_W   = 31;
   localparam int SUM_W   = 32;
   localparam int ROOT_STEPS = (MAG_W + 1) / 2;

   // shared divider for texture coordinates and triangle lookup
   localparam int NUM_W   = 25;
   localparam int DEN_W   = 10;

   localparam int REQ_W   = 32;
   localparam int RSP_W   = 144;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 1'b1;

   localparam logic [DIM_W-1:0] MIN_DIM = 9'd2;
   localparam logic signed [VEC_W-1:0] FACE_Y = 17'sd10;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_BUILD = 2'd1,
      REQ_VREAD = 2'd2,
      REQ_TREAD = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_UNBUILT = 2'd2
   } status_type;

endpackage

FILE: hdl/heightmap_terrain_mesh_builder_unit.sv
// Terrain grid mesh builder. Heights are loaded one per beat; a build request clears the
// normal store (one entry a cycle over columns x rows vertices) and then walks every cell,
// making two triangles and updating the normals of their corners. Every normalisation runs
// on one shared iterative unit: three squares, a 31-step divide and a 16-step square root
// per component. A vertex read makes three passes through the shared 25-bit serial divider
// and a triangle read makes one. The block takes one request at a time; a finished result
// waits in the output register while the next request is accepted.
module heightmap_terrain_mesh_builder_unit
   import hmtmb_pkg::*;
#(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // req_type[1:0], item_index[18:2], height_value[26:19]
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // status[1:0], vertex_height[9:2], normal_x[25:10], normal_y[41:26], normal_z[57:42],
   // tex_u[73:58], tex_v[89:74], corner_first[105:90], corner_second[121:106],
   // corner_third[137:122]
   output logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [4:0] {
      S_IDLE,
      S_SIZE,
      S_DISP,
      S_CLR,
      S_HGT,
      S_FACE,
      S_FWAIT,
      S_NRD,
      S_NADD,
      S_NWAIT,
      S_NEXT,
      S_VDIV,
      S_UDIV,
      S_VTDIV,
      S_TDIV,
      S_TOUT,
      S_DONE
   } state_type;

   state_type          state_ff;
   req_kind_type       kind_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [HGT_W-1:0]   hv_ff;
   logic [DIM_W-1:0]   cols_ff, rows_ff, w_ff, h_ff;
   logic               built_ff;
   logic [NV_W-1:0]    nverts_ff;
   logic [NT_W-1:0]    ntri_ff;
   logic [NV_W-1:0]    base_ff, clr_ff;
   logic [DIM_W-1:0]   c_ff, r_ff;
   logic [2:0]         step_ff;
   logic [HGT_W-1:0]   hq_ff [4];
   logic               tri_ff;
   logic [1:0]         j_ff;
   logic [NRM_W-1:0]   fn_x_ff, fn_y_ff, fn_z_ff;

   logic [1:0]         res_status_ff;
   logic [HGT_W-1:0]   res_height_ff;
   logic [NRM_W-1:0]   res_nx_ff, res_ny_ff, res_nz_ff, res_u_ff, res_v_ff;
   logic [15:0]        res_c1_ff, res_c2_ff, res_c3_ff;

   logic               rsp_valid_ff;
   logic [1:0]         out_status_ff;
   logic [HGT_W-1:0]   out_height_ff;
   logic [NRM_W-1:0]   out_nx_ff, out_ny_ff, out_nz_ff, out_u_ff, out_v_ff;
   logic [15:0]        out_c1_ff, out_c2_ff, out_c3_ff;

   logic [HGT_W-1:0]   height_mem [DEPTH];
   logic [3*NRM_W-1:0] normal_mem [DEPTH];
   logic [HGT_W-1:0]   height_q_ff;
   logic [3*NRM_W-1:0] normal_q_ff;

   logic [DIM_W-1:0]   w_in, h_in, wm1, hm1;
   logic [NV_W-1:0]    i0, i1, i2, i3, corner, hrd_addr, nrd_addr;
   logic               idx_bad_v, idx_bad_t;
   logic               hwr_en, nwr_en;
   logic [NV_W-1:0]    nwr_addr;
   logic [3*NRM_W-1:0] nwr_data;

   logic                    norm_start, norm_done;
   logic signed [VEC_W-1:0] nv_x, nv_y, nv_z;
   logic signed [NRM_W-1:0] nr_x, nr_y, nr_z;

   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_num, div_quo;
   logic [DEN_W-1:0]   div_den, div_rem;

   // saturate grid size to the supported range
   always_comb begin
      if (cols_ff < MIN_DIM) begin
         w_in = MIN_DIM;
      end else if (32'(cols_ff) > 32'(MAX_COLUMNS)) begin
         w_in = DIM_W'(MAX_COLUMNS);
      end else begin
         w_in = cols_ff;
      end
      if (rows_ff < MIN_DIM) begin
         h_in = MIN_DIM;
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         h_in = DIM_W'(MAX_ROWS);
      end else begin
         h_in = rows_ff;
      end
   end

   assign wm1 = w_ff - DIM_W'(1);
   assign hm1 = h_ff - DIM_W'(1);

   // corners of the current cell
   assign i3 = base_ff;
   assign i2 = base_ff + NV_W'(1);
   assign i0 = base_ff + NV_W'(w_ff);
   assign i1 = i0 + NV_W'(1);

   always_comb begin
      corner = i0;
      case (j_ff)
         2'd1:    corner = tri_ff ? i2 : i1;
         2'd2:    corner = tri_ff ? i3 : i2;
         default: corner = i0;
      endcase
      hrd_addr = NV_W'(idx_ff);
      if (state_ff == S_HGT) begin
         case (step_ff)
            3'd0:    hrd_addr = i0;
            3'd1:    hrd_addr = i1;
            3'd2:    hrd_addr = i2;
            default: hrd_addr = i3;
         endcase
      end
      nrd_addr = (state_ff == S_NRD) ? corner : NV_W'(idx_ff);
   end

   assign idx_bad_v = (NV_W'(idx_ff) >= nverts_ff);
   assign idx_bad_t = (NT_W'(idx_ff) >= ntri_ff);

   assign hwr_en   = (state_ff == S_DISP) && (kind_ff == REQ_LOAD) && !idx_bad_v;
   assign nwr_en   = (state_ff == S_CLR) || ((state_ff == S_NWAIT) && norm_done);
   assign nwr_addr = (state_ff == S_CLR) ? clr_ff : corner;
   assign nwr_data = (state_ff == S_CLR) ? '0 : {nr_z, nr_y, nr_x};

   always_ff @(posedge clock) begin
      if (hwr_en) begin
         height_mem[AW'(idx_ff)] <= hv_ff;
      end
      height_q_ff <= height_mem[AW'(hrd_addr)];
   end

   always_ff @(posedge clock) begin
      if (nwr_en) begin
         normal_mem[AW'(nwr_addr)] <= nwr_data;
      end
      normal_q_ff <= normal_mem[AW'(nrd_addr)];
   end

   // operands for the shared normaliser
   assign norm_start = (state_ff == S_FACE) || (state_ff == S_NADD);
   always_comb begin
      if (state_ff == S_NADD) begin
         nv_x = $signed({normal_q_ff[NRM_W-1], normal_q_ff[NRM_W-1:0]})
              + $signed({fn_x_ff[NRM_W-1], fn_x_ff});
         nv_y = $signed({normal_q_ff[2*NRM_W-1], normal_q_ff[2*NRM_W-1:NRM_W]})
              + $signed({fn_y_ff[NRM_W-1], fn_y_ff});
         nv_z = $signed({normal_q_ff[3*NRM_W-1], normal_q_ff[3*NRM_W-1:2*NRM_W]})
              + $signed({fn_z_ff[NRM_W-1], fn_z_ff});
      end else if (tri_ff) begin
         nv_x = $signed(VEC_W'(hq_ff[3])) - $signed(VEC_W'(hq_ff[2]));
         nv_y = FACE_Y;
         nv_z = $signed(VEC_W'(hq_ff[3])) - $signed(VEC_W'(hq_ff[0]));
      end else begin
         nv_x = $signed(VEC_W'(hq_ff[0])) - $signed(VEC_W'(hq_ff[1]));
         nv_y = FACE_Y;
         nv_z = $signed(VEC_W'(hq_ff[2])) - $signed(VEC_W'(hq_ff[1]));
      end
   end

   hmtmb_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec_x (nv_x),
      .vec_y (nv_y),
      .vec_z (nv_z),
      .done  (norm_done),
      .nrm_x (nr_x),
      .nrm_y (nr_y),
      .nrm_z (nr_z)
   );

   // operands for the shared divider
   always_comb begin
      div_start = 1'b0;
      div_num   = NUM_W'(idx_ff);
      div_den   = DEN_W'(w_ff);
      case (state_ff)
         S_DISP: begin
            if (kind_ff == REQ_VREAD) begin
               div_start = !idx_bad_v && built_ff;
            end else if (kind_ff == REQ_TREAD) begin
               div_start = !idx_bad_t && built_ff;
               div_num   = NUM_W'(idx_ff >> 1);
               div_den   = DEN_W'(wm1);
            end
         end
         S_VDIV: begin
            div_start = div_done;
            div_num   = (NUM_W'(div_rem) << 16) + NUM_W'(wm1);
            div_den   = {wm1, 1'b0};
         end
         S_UDIV: begin
            div_start = div_done;
            div_num   = (NUM_W'(r_ff) << 16) + NUM_W'(hm1);
            div_den   = {hm1, 1'b0};
         end
         default: div_start = 1'b0;
      endcase
   end

   hmtmb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cols_ff      <= DIM_W'(256);
         rows_ff      <= DIM_W'(256);
         w_ff         <= MIN_DIM;
         h_ff         <= MIN_DIM;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_ff <= w_in;
         h_ff <= h_in;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff       <= req_kind_type'(req_tdata[1:0]);
                  idx_ff        <= req_tdata[IDX_W+1:2];
                  hv_ff         <= req_tdata[IDX_W+HGT_W+1:IDX_W+2];
                  res_status_ff <= ST_OK;
                  res_height_ff <= '0;
                  res_nx_ff     <= '0;
                  res_ny_ff     <= '0;
                  res_nz_ff     <= '0;
                  res_u_ff      <= '0;
                  res_v_ff      <= '0;
                  res_c1_ff     <= '0;
                  res_c2_ff     <= '0;
                  res_c3_ff     <= '0;
                  state_ff      <= S_SIZE;
               end
            end
            S_SIZE: begin
               nverts_ff <= NV_W'(w_ff) * NV_W'(h_ff);
               ntri_ff   <= {NV_W'(wm1) * NV_W'(hm1), 1'b0};
               state_ff  <= S_DISP;
            end
            S_DISP: begin
               case (kind_ff)
                  REQ_LOAD: begin
                     if (idx_bad_v) begin
                        res_status_ff <= ST_RANGE;
                     end
                     state_ff <= S_DONE;
                  end
                  REQ_BUILD: begin
                     clr_ff   <= '0;
                     state_ff <= S_CLR;
                  end
                  REQ_VREAD: begin
                     if (idx_bad_v) begin
                        res_status_ff <= ST_RANGE;
                        state_ff      <= S_DONE;
                     end else if (!built_ff) begin
                        res_status_ff <= ST_UNBUILT;
                        state_ff      <= S_DONE;
                     end else begin
                        state_ff <= S_VDIV;
                     end
                  end
                  default: begin
                     if (idx_bad_t) begin
                        res_status_ff <= ST_RANGE;
                        state_ff      <= S_DONE;
                     end else if (!built_ff) begin
                        res_status_ff <= ST_UNBUILT;
                        state_ff      <= S_DONE;
                     end else begin
                        state_ff <= S_TDIV;
                     end
                  end
               endcase
            end
            S_CLR: begin
               clr_ff <= clr_ff + NV_W'(1);
               if (clr_ff == nverts_ff - NV_W'(1)) begin
                  base_ff  <= '0;
                  c_ff     <= '0;
                  r_ff     <= '0;
                  tri_ff   <= 1'b0;
                  step_ff  <= 3'd0;
                  state_ff <= S_HGT;
               end
            end
            S_HGT: begin
               // read port data arrives in the cycle after its address
               if (step_ff != 3'd0) begin
                  hq_ff[2'(step_ff - 3'd1)] <= height_q_ff;
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd4) begin
                  state_ff <= S_FACE;
               end
            end
            S_FACE: begin
               state_ff <= S_FWAIT;
            end
            S_FWAIT: begin
               if (norm_done) begin
                  fn_x_ff  <= nr_x;
                  fn_y_ff  <= nr_y;
                  fn_z_ff  <= nr_z;
                  j_ff     <= 2'd0;
                  state_ff <= S_NRD;
               end
            end
            S_NRD: begin
               state_ff <= S_NADD;
            end
            S_NADD: begin
               state_ff <= S_NWAIT;
            end
            S_NWAIT: begin
               if (norm_done) begin
                  if (j_ff != 2'd2) begin
                     j_ff     <= j_ff + 2'd1;
                     state_ff <= S_NRD;
                  end else if (!tri_ff) begin
                     tri_ff   <= 1'b1;
                     state_ff <= S_FACE;
                  end else begin
                     state_ff <= S_NEXT;
                  end
               end
            end
            S_NEXT: begin
               tri_ff  <= 1'b0;
               step_ff <= 3'd0;
               if (c_ff == w_ff - DIM_W'(2)) begin
                  if (r_ff == h_ff - DIM_W'(2)) begin
                     built_ff <= 1'b1;
                     state_ff <= S_DONE;
                  end else begin
                     c_ff     <= '0;
                     r_ff     <= r_ff + DIM_W'(1);
                     base_ff  <= base_ff + NV_W'(2);
                     state_ff <= S_HGT;
                  end
               end else begin
                  c_ff     <= c_ff + DIM_W'(1);
                  base_ff  <= base_ff + NV_W'(1);
                  state_ff <= S_HGT;
               end
            end
            S_VDIV: begin
               if (div_done) begin
                  r_ff     <= DIM_W'(div_quo);
                  state_ff <= S_UDIV;
               end
            end
            S_UDIV: begin
               if (div_done) begin
                  res_u_ff <= NRM_W'(div_quo);
                  state_ff <= S_VTDIV;
               end
            end
            S_VTDIV: begin
               if (div_done) begin
                  res_v_ff      <= NRM_W'(div_quo);
                  res_height_ff <= height_q_ff;
                  res_nx_ff     <= normal_q_ff[NRM_W-1:0];
                  res_ny_ff     <= normal_q_ff[2*NRM_W-1:NRM_W];
                  res_nz_ff     <= normal_q_ff[3*NRM_W-1:2*NRM_W];
                  state_ff      <= S_DONE;
               end
            end
            S_TDIV: begin
               if (div_done) begin
                  base_ff  <= NV_W'(div_quo[15:0] * w_ff) + NV_W'(div_rem);
                  state_ff <= S_TOUT;
               end
            end
            S_TOUT: begin
               res_c1_ff <= 16'(i0);
               if (idx_ff[0]) begin
                  res_c2_ff <= 16'(i2);
                  res_c3_ff <= 16'(i3);
               end else begin
                  res_c2_ff <= 16'(i1);
                  res_c3_ff <= 16'(i2);
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  out_status_ff <= res_status_ff;
                  out_height_ff <= res_height_ff;
                  out_nx_ff     <= res_nx_ff;
                  out_ny_ff     <= res_ny_ff;
                  out_nz_ff     <= res_nz_ff;
                  out_u_ff      <= res_u_ff;
                  out_v_ff      <= res_v_ff;
                  out_c1_ff     <= res_c1_ff;
                  out_c2_ff     <= res_c2_ff;
                  out_c3_ff     <= res_c3_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // the user must write grid size only while idle; the block itself does not enforce it
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COLUMNS: cols_ff <= csr_wdata;
               CSR_ROWS:    rows_ff <= csr_wdata;
               default:     cols_ff <= cols_ff;
            endcase
            built_ff <= 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_c3_ff, out_c2_ff, out_c1_ff, out_v_ff, out_u_ff,
                        out_nz_ff, out_ny_ff, out_nx_ff, out_height_ff, out_status_ff};

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous one still running");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_status_ff != ST_OK) |->
      (out_height_ff == '0 && out_nx_ff == '0 && out_ny_ff == '0 && out_nz_ff == '0
       && out_c1_ff == '0 && out_u_ff == '0))
      else $error("error beat carries payload");
   assert property (@(posedge clock) disable iff (reset)
      $fell(built_ff) |-> $past(csr_wr_en))
      else $error("built flag lost without a register write");

endmodule

FILE: hdl/hmtmb_div.sv
module hmtmb_div
   import hmtmb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W:0]   trial;
   logic             take;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign take  = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(NUM_W);
            num_ff <= num;
            den_ff <= den;
            quo_ff <= '0;
            rem_ff <= '0;
         end else if (run_ff) begin
            num_ff <= num_ff << 1;
            quo_ff <= {quo_ff[NUM_W-2:0], take};
            rem_ff <= take ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

   assert property (@(posedge clock) disable iff (reset) done |=> !done)
      else $error("divider done held");
   assert property (@(posedge clock) disable iff (reset) start |-> !run_ff)
      else $error("divider restarted while busy");
   assert property (@(posedge clock) disable iff (reset) done |-> rem < den_ff)
      else $error("divider remainder not below divisor");

endmodule

FILE: hdl/hmtmb_norm.sv
module hmtmb_norm
   import hmtmb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [VEC_W-1:0] vec_x,
   input  logic signed [VEC_W-1:0] vec_y,
   input  logic signed [VEC_W-1:0] vec_z,
   output logic                    done,
   output logic signed [NRM_W-1:0] nrm_x,
   output logic signed [NRM_W-1:0] nrm_y,
   output logic signed [NRM_W-1:0] nrm_z
);

   typedef enum logic [2:0] {
      N_IDLE,
      N_SQ,
      N_SUM,
      N_LOAD,
      N_DIV,
      N_ROOT,
      N_DONE
   } nstate_type;

   nstate_type              state_ff;
   logic                    done_ff;
   logic [1:0]              k_ff;
   logic [4:0]              cnt_ff;
   logic signed [VEC_W-1:0] v_ff [3];
   logic [MAG_W-1:0]        mag_ff [3];
   logic [SUM_W-1:0]        sum_ff;
   logic [SUM_W:0]          rem_ff;
   logic [MAG_W-1:0]        quo_ff;
   logic [SUM_W-1:0]        root_ff;
   logic [SUM_W-1:0]        bit_ff;
   logic signed [NRM_W-1:0] out_ff [3];

   logic signed [VEC_W-1:0] cur;
   logic [VEC_W-1:0]        abs_v;
   logic [2*VEC_W-1:0]      sq;
   logic [SUM_W:0]          trial;
   logic                    take;
   logic [MAG_W-1:0]        quo_in;
   logic [SUM_W:0]          rtest;
   logic                    rtake;
   logic [SUM_W-1:0]        root_in;
   logic [NRM_W-1:0]        mag_res;

   always_comb begin
      cur     = v_ff[k_ff];
      abs_v   = cur[VEC_W-1] ? VEC_W'(-cur) : VEC_W'(cur);
      sq      = abs_v * abs_v;
      trial   = (cnt_ff == 5'd0) ? rem_ff : (rem_ff << 1);
      take    = (trial >= {1'b0, sum_ff});
      quo_in  = {quo_ff[MAG_W-2:0], take};
      rtest   = {1'b0, root_ff + bit_ff};
      rtake   = (rem_ff >= rtest);
      root_in = rtake ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);
      mag_res = NRM_W'((root_in + SUM_W'(1)) >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            N_IDLE: begin
               if (start) begin
                  v_ff[0]  <= vec_x;
                  v_ff[1]  <= vec_y;
                  v_ff[2]  <= vec_z;
                  k_ff     <= 2'd0;
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               mag_ff[k_ff] <= sq[MAG_W-1:0];
               if (k_ff == 2'd2) begin
                  state_ff <= N_SUM;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            N_SUM: begin
               sum_ff   <= SUM_W'(mag_ff[0]) + SUM_W'(mag_ff[1]) + SUM_W'(mag_ff[2]);
               k_ff     <= 2'd0;
               state_ff <= N_LOAD;
            end
            N_LOAD: begin
               if (sum_ff == '0) begin
                  out_ff[0] <= '0;
                  out_ff[1] <= '0;
                  out_ff[2] <= '0;
                  state_ff  <= N_DONE;
               end else begin
                  rem_ff   <= (SUM_W+1)'(mag_ff[k_ff]);
                  quo_ff   <= '0;
                  cnt_ff   <= 5'd0;
                  state_ff <= N_DIV;
               end
            end
            N_DIV: begin
               // mag * 2^30 / sum, first step without a shift
               quo_ff <= quo_in;
               if (cnt_ff == 5'(MAG_W - 1)) begin
                  rem_ff   <= (SUM_W+1)'(quo_in);
                  root_ff  <= '0;
                  bit_ff   <= SUM_W'(1) << (MAG_W - 1);
                  cnt_ff   <= 5'd0;
                  state_ff <= N_ROOT;
               end else begin
                  rem_ff <= take ? (trial - {1'b0, sum_ff}) : trial;
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            N_ROOT: begin
               if (rtake) begin
                  rem_ff <= rem_ff - rtest;
               end
               root_ff <= root_in;
               bit_ff  <= bit_ff >> 2;
               cnt_ff  <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(ROOT_STEPS - 1)) begin
                  out_ff[k_ff] <= cur[VEC_W-1] ? -$signed(mag_res) : $signed(mag_res);
                  if (k_ff == 2'd2) begin
                     state_ff <= N_DONE;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= N_LOAD;
                  end
               end
            end
            N_DONE: begin
               done_ff  <= 1'b1;
               state_ff <= N_IDLE;
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign nrm_x = out_ff[0];
   assign nrm_y = out_ff[1];
   assign nrm_z = out_ff[2];

   assert property (@(posedge clock) disable iff (reset) done |=> !done)
      else $error("normaliser done held");
   assert property (@(posedge clock) disable iff (reset) start |-> state_ff == N_IDLE)
      else $error("normaliser started while busy");
   assert property (@(posedge clock) disable iff (reset)
      done |-> (nrm_x >= -16384 && nrm_x <= 16384 && nrm_y >= -16384 && nrm_y <= 16384
               && nrm_z >= -16384 && nrm_z <= 16384))
      else $error("normal component beyond unit range");

endmodule
